// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/moa_pkg.sv
// ---------------------------------------------------------------------------
// moa_pkg
// types, widths and the arctangent table of the marker orientation block
// ---------------------------------------------------------------------------
package moa_pkg;

    localparam int COORD_WIDTH       = 16;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int TAB_LEN           = 24;
    localparam int NUM_ITER = (CORDIC_ITERATIONS < TAB_LEN) ? CORDIC_ITERATIONS : TAB_LEN;

    localparam int PRE_SHIFT  = 24;
    // cordic x/y: magnitude stays below 2.4 * 2^(COORD_WIDTH + PRE_SHIFT)
    localparam int XW         = COORD_WIDTH + PRE_SHIFT + 3;
    localparam int ANGLE_FRAC = 16;
    localparam int ZW         = 25;
    localparam int RAW_W      = 25;
    localparam int OFFSET_W   = 9;
    localparam int ANGLE_W    = 9;

    localparam logic [RAW_W-1:0] ANG_90  = RAW_W'(90 * (1 << ANGLE_FRAC));
    localparam logic [RAW_W-1:0] ANG_180 = RAW_W'(180 * (1 << ANGLE_FRAC));
    localparam logic [RAW_W-1:0] ANG_360 = RAW_W'(360 * (1 << ANGLE_FRAC));
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(45);
    localparam logic [OFFSET_W-1:0] DEG_360      = OFFSET_W'(360);

    typedef struct packed {
        logic [COORD_WIDTH-1:0] point_x;
        logic [COORD_WIDTH-1:0] point_y;
        logic [COORD_WIDTH-1:0] center_x;
        logic [COORD_WIDTH-1:0] center_y;
    } in_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_deg;
        logic               degenerate;
    } out_t;

    // flags that ride along the cordic pipeline
    typedef struct packed {
        logic degenerate;
        logic zero_a;
        logic zero_b;
        logic neg_u;
        logic neg_v;
    } side_t;

    // atan(2^-i) in degrees, 16 fraction bits, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_angle(input int unsigned idx);
        case (idx)
            0:       return ZW'(2949120);
            1:       return ZW'(1740967);
            2:       return ZW'(919879);
            3:       return ZW'(466945);
            4:       return ZW'(234379);
            5:       return ZW'(117304);
            6:       return ZW'(58666);
            7:       return ZW'(29335);
            8:       return ZW'(14668);
            9:       return ZW'(7334);
            10:      return ZW'(3667);
            11:      return ZW'(1833);
            12:      return ZW'(917);
            13:      return ZW'(458);
            14:      return ZW'(229);
            15:      return ZW'(115);
            16:      return ZW'(57);
            17:      return ZW'(29);
            18:      return ZW'(14);
            19:      return ZW'(7);
            20:      return ZW'(4);
            21:      return ZW'(2);
            22:      return ZW'(1);
            default: return '0;
        endcase
    endfunction

endpackage

// File: rtl/moa_cordic.sv
// ---------------------------------------------------------------------------
// moa_cordic
// pipelined vectoring cordic, one rotation per register stage
// ---------------------------------------------------------------------------
module moa_cordic (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [moa_pkg::COORD_WIDTH-1:0]       in_a,
    input  logic [moa_pkg::COORD_WIDTH-1:0]       in_b,
    input  moa_pkg::side_t                        in_side,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [moa_pkg::ZW-1:0]         out_z,
    output moa_pkg::side_t                        out_side
);

    logic signed [moa_pkg::XW-1:0] x_reg    [moa_pkg::NUM_ITER];
    logic signed [moa_pkg::XW-1:0] y_reg    [moa_pkg::NUM_ITER];
    logic signed [moa_pkg::ZW-1:0] z_reg    [moa_pkg::NUM_ITER];
    moa_pkg::side_t                side_reg [moa_pkg::NUM_ITER];
    logic                          v_reg    [moa_pkg::NUM_ITER];
    logic [moa_pkg::NUM_ITER:0]    rdy;

    assign rdy[moa_pkg::NUM_ITER] = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[moa_pkg::NUM_ITER-1];
    assign out_z     = z_reg[moa_pkg::NUM_ITER-1];
    assign out_side  = side_reg[moa_pkg::NUM_ITER-1];

    genvar i;
    for (i = 0; i < moa_pkg::NUM_ITER; i++) begin : g_stage
        logic signed [moa_pkg::XW-1:0] x_cur;
        logic signed [moa_pkg::XW-1:0] y_cur;
        logic signed [moa_pkg::ZW-1:0] z_cur;
        moa_pkg::side_t                side_cur;
        logic                          v_cur;
        logic signed [moa_pkg::XW-1:0] x_next;
        logic signed [moa_pkg::XW-1:0] y_next;
        logic signed [moa_pkg::ZW-1:0] z_next;

        if (i == 0) begin : g_first
            assign x_cur    = {3'b000, in_a, {moa_pkg::PRE_SHIFT{1'b0}}};
            assign y_cur    = {3'b000, in_b, {moa_pkg::PRE_SHIFT{1'b0}}};
            assign z_cur    = '0;
            assign side_cur = in_side;
            assign v_cur    = in_valid;
        end else begin : g_rest
            assign x_cur    = x_reg[i-1];
            assign y_cur    = y_reg[i-1];
            assign z_cur    = z_reg[i-1];
            assign side_cur = side_reg[i-1];
            assign v_cur    = v_reg[i-1];
        end

        // arithmetic shift of y rounds toward minus infinity; x never goes negative
        always_comb begin
            if (y_cur > 0) begin
                x_next = x_cur + (y_cur >>> i);
                y_next = y_cur - (x_cur >>> i);
                z_next = z_cur + moa_pkg::atan_angle(i);
            end else begin
                x_next = x_cur - (y_cur >>> i);
                y_next = y_cur + (x_cur >>> i);
                z_next = z_cur - moa_pkg::atan_angle(i);
            end
        end

        assign rdy[i] = !v_reg[i] || rdy[i+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (rdy[i]) begin
                v_reg[i] <= v_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[i] && v_cur) begin
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                z_reg[i]    <= z_next;
                side_reg[i] <= side_cur;
            end
        end
    end

endmodule

// File: rtl/marker_orientation_angle.sv
// ---------------------------------------------------------------------------
// marker_orientation_angle
// orientation of a corner point about a box center in whole degrees
// ---------------------------------------------------------------------------
//  port group   direction  contents
//  s_*          in         corner and center, unsigned Q12.4 (in_t)
//  m_*          out        angle_deg 0..359 and degenerate flag (out_t)
//  cfg_*        in         angle_offset write, 9 bits, always ready
//
//  one transaction per cycle in, one per cycle out while m_ready holds; the registers
//  are the front stage, one per cordic rotation, the quadrant stage and the output stage
//  reset clears all valid bits and loads angle_offset with 45
//  every stage holds while the one after it is full and stalled; empty
//  stages fill up, so input keeps flowing while a result waits at m_*
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module marker_orientation_angle (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  moa_pkg::in_t                  s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output moa_pkg::out_t                 m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [moa_pkg::OFFSET_W-1:0]  cfg_data
);

    // offset register, stored already reduced below 360
    logic [moa_pkg::OFFSET_W-1:0] offset_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= moa_pkg::OFFSET_RESET;
        end else if (cfg_valid) begin
            offset_reg <= (cfg_data >= moa_pkg::DEG_360) ? cfg_data - moa_pkg::DEG_360
                                                         : cfg_data;
        end
    end

    // front stage: difference vector, magnitudes, special-case flags
    logic                              f_valid_reg;
    logic [moa_pkg::COORD_WIDTH-1:0]   f_a_reg;
    logic [moa_pkg::COORD_WIDTH-1:0]   f_b_reg;
    moa_pkg::side_t                    f_side_reg;
    logic                              f_ready;
    logic signed [moa_pkg::COORD_WIDTH:0] u_diff;
    logic signed [moa_pkg::COORD_WIDTH:0] v_diff;
    logic signed [moa_pkg::COORD_WIDTH:0] u_abs;
    logic signed [moa_pkg::COORD_WIDTH:0] v_abs;
    moa_pkg::side_t                    side_next;

    logic                              c_ready;
    logic                              c_valid;
    logic signed [moa_pkg::ZW-1:0]     c_z;
    moa_pkg::side_t                    c_side;
    logic                              q_ready;
    logic                              o_ready;

    always_comb begin
        u_diff = $signed({1'b0, s_data.center_x}) - $signed({1'b0, s_data.point_x});
        v_diff = $signed({1'b0, s_data.center_y}) - $signed({1'b0, s_data.point_y});
        u_abs  = u_diff[moa_pkg::COORD_WIDTH] ? -u_diff : u_diff;
        v_abs  = v_diff[moa_pkg::COORD_WIDTH] ? -v_diff : v_diff;
        side_next.zero_a     = (u_diff == '0);
        side_next.zero_b     = (v_diff == '0);
        side_next.degenerate = (u_diff == '0) && (v_diff == '0);
        side_next.neg_u      = u_diff[moa_pkg::COORD_WIDTH];
        side_next.neg_v      = v_diff[moa_pkg::COORD_WIDTH];
    end

    assign f_ready = !f_valid_reg || c_ready;
    assign s_ready = f_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (f_ready) begin
            f_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (f_ready && s_valid) begin
            f_a_reg    <= u_abs[moa_pkg::COORD_WIDTH-1:0];
            f_b_reg    <= v_abs[moa_pkg::COORD_WIDTH-1:0];
            f_side_reg <= side_next;
        end
    end

    moa_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid_reg),
        .in_ready  (c_ready),
        .in_a      (f_a_reg),
        .in_b      (f_b_reg),
        .in_side   (f_side_reg),
        .out_valid (c_valid),
        .out_ready (q_ready),
        .out_z     (c_z),
        .out_side  (c_side)
    );

    // quadrant stage: clamp, special axes, map into the range [0, 360)
    logic                          q_valid_reg;
    logic [moa_pkg::RAW_W-1:0]     q_raw_reg;
    logic                          q_degen_reg;
    logic [moa_pkg::RAW_W-1:0]     th;
    logic [moa_pkg::RAW_W-1:0]     raw;

    always_comb begin
        if (c_side.zero_b) begin
            th = '0;
        end else if (c_side.zero_a) begin
            th = moa_pkg::ANG_90;
        end else if (c_z < 0) begin
            th = '0;
        end else if (moa_pkg::RAW_W'(c_z) > moa_pkg::ANG_90) begin
            th = moa_pkg::ANG_90;
        end else begin
            th = moa_pkg::RAW_W'(c_z);
        end

        if (!c_side.neg_u && !c_side.neg_v) begin
            raw = th;
        end else if (c_side.neg_u && !c_side.neg_v) begin
            raw = moa_pkg::ANG_180 - th;
        end else if (c_side.neg_u) begin
            raw = moa_pkg::ANG_180 + th;
        end else begin
            raw = moa_pkg::ANG_360 - th;
        end
        if (raw >= moa_pkg::ANG_360) begin
            raw = raw - moa_pkg::ANG_360;
        end
    end

    assign q_ready = !q_valid_reg || o_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= 1'b0;
        end else if (q_ready) begin
            q_valid_reg <= c_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_ready && c_valid) begin
            q_raw_reg   <= raw;
            q_degen_reg <= c_side.degenerate;
        end
    end

    // output stage: subtract offset, wrap, truncate to whole degrees, zero if degenerate
    logic                          m_valid_reg;
    moa_pkg::out_t                 m_data_reg;
    moa_pkg::out_t                 m_data_next;
    logic [moa_pkg::RAW_W:0]       res;

    always_comb begin
        res = {1'b0, q_raw_reg}
            - {1'b0, offset_reg, {moa_pkg::ANGLE_FRAC{1'b0}}};
        if (res[moa_pkg::RAW_W]) begin
            res = res + {1'b0, moa_pkg::ANG_360};
        end
        m_data_next.degenerate = q_degen_reg;
        m_data_next.angle_deg  = q_degen_reg ? '0
            : res[moa_pkg::ANGLE_FRAC+moa_pkg::ANGLE_W-1:moa_pkg::ANGLE_FRAC];
    end

    assign o_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (o_ready) begin
            m_valid_reg <= q_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (o_ready && q_valid_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a full pipeline is the only way the input side can be held off
    `ASSERT_IMPLIES(a_stall_from_output, aclk, aresetn, !s_ready, m_valid && !m_ready)
    `ASSERT_IMPLIES(a_angle_range, aclk, aresetn, m_valid, m_data.angle_deg < 9'd360)
    `ASSERT_IMPLIES(a_degen_zero, aclk, aresetn, m_valid && m_data.degenerate,
                    m_data.angle_deg == '0)
    `ASSERT_NEXT(a_offset_reduced, aclk, aresetn, cfg_valid, offset_reg < moa_pkg::DEG_360)

endmodule
